### hw/rtl/kcs_pkg.sv
// Shared types, codes and helpers for the keyword category scorer.
package kcs_pkg;

    // Request codes carried in the op field.
    localparam logic [1:0] OP_KEY_CHAR  = 2'd0;
    localparam logic [1:0] OP_KEY_COUNT = 2'd1;
    localparam logic [1:0] OP_TEXT      = 2'd2;

    // Upper bound on results per run, set by the width of result_category.
    localparam int RESULT_LIMIT = 16;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [1:0] op;
        logic [3:0] category;
        logic [3:0] keyword;
        logic [4:0] position;
        logic [7:0] char_value;
        logic [4:0] keyword_count;
        logic       end_flag;
    } req_t;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [3:0] result_category;
        logic [4:0] score;
        logic       last;
        logic [3:0] best_category;
        logic       found;
    } res_t;

    // Command kinds passed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_TEXT  = 2'd2
    } cmd_kind_t;

    // A classified command as held in the queue.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] category;
        logic [3:0] keyword;
        logic [4:0] position;
        logic [7:0] char_value;
        logic [4:0] keyword_count;
        logic       end_flag;
    } cmd_t;

    // Fold upper-case ASCII letters to lower case; all other bytes pass.
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### hw/rtl/kcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/kcs_front.sv
// Front end: accepts requests, drops ignored ones and classifies the rest.
module kcs_front import kcs_pkg::*; #(
    parameter int CATEGORIES            = 16,
    parameter int KEYWORDS_PER_CATEGORY = 16,
    parameter int KEYWORD_CHARS         = 31
) (
    input  logic req_valid,
    input  req_t req,
    output logic req_stall,
    input  logic q_full,
    output logic push,
    output cmd_t push_data
);

    logic keep;

    // Classify the request and check the load ranges.
    always_comb
    begin
        keep                    = 1'b0;
        push_data.kind          = CMD_TEXT;
        push_data.category      = req.category;
        push_data.keyword       = req.keyword;
        push_data.position      = req.position;
        push_data.char_value    = fold_char(req.char_value);
        push_data.end_flag      = req.end_flag;
        push_data.keyword_count = req.keyword_count;
        if (int'(req.keyword_count) > KEYWORDS_PER_CATEGORY)
        begin
            push_data.keyword_count = 5'(KEYWORDS_PER_CATEGORY);
        end
        case (req.op)
            OP_KEY_CHAR:
            begin
                push_data.kind = CMD_CHAR;
                keep = (int'(req.category) < CATEGORIES)
                    && (int'(req.keyword) < KEYWORDS_PER_CATEGORY)
                    && (int'(req.position) < KEYWORD_CHARS);
            end
            OP_KEY_COUNT:
            begin
                push_data.kind = CMD_COUNT;
                keep = int'(req.category) < CATEGORIES;
            end
            OP_TEXT:
            begin
                push_data.kind = CMD_TEXT;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // The front end only waits when the queue is full.
    assign req_stall = q_full;
    assign push      = req_valid && !q_full && keep;

endmodule

### hw/rtl/kcs_queue.sv
// Two-entry command queue between the front end and the back end.
module kcs_queue import kcs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full       = fill_reg == 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The back end never pops an empty queue, and nothing is pushed when full.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("queue popped while empty");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue pushed while full");

endmodule

### hw/rtl/kcs_back.sv
// Back end: keyword table updates, per-character match scan and scoring.
module kcs_back import kcs_pkg::*; #(
    parameter int CATEGORIES            = 16,
    parameter int KEYWORDS_PER_CATEGORY = 16,
    parameter int KEYWORD_CHARS         = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       res_valid,
    output res_t       res,
    input  logic       res_stall
);

    localparam int SLOTS      = CATEGORIES * KEYWORDS_PER_CATEGORY;
    localparam int SLOT_W     = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int POS_W      = KEYWORD_CHARS > 1 ? $clog2(KEYWORD_CHARS) : 1;
    localparam int LEN_W      = $clog2(KEYWORD_CHARS + 1);
    localparam int CHARS_W    = KEYWORD_CHARS * 8;
    localparam int ROW_W      = LEN_W + CHARS_W;
    localparam int ST_W       = KEYWORD_CHARS + 1;
    localparam int KW_W       = KEYWORDS_PER_CATEGORY > 1 ? $clog2(KEYWORDS_PER_CATEGORY) : 1;
    localparam int CAT_W      = CATEGORIES > 1 ? $clog2(CATEGORIES) : 1;
    localparam int CNT_W      = $clog2(KEYWORDS_PER_CATEGORY + 1);
    localparam int USED_LIMIT = CATEGORIES < RESULT_LIMIT ? CATEGORIES : RESULT_LIMIT;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [KW_W-1:0]   LAST_KW   = KW_W'(KEYWORDS_PER_CATEGORY - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ROW_WR   = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_SCAN_END = 7'b0001000,
        S_SCORE    = 7'b0010000,
        S_SUM_END  = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [4:0]           cfg_reg;
    logic [CNT_W-1:0]     counts_reg [CATEGORIES];
    logic                 cnt_we;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [KW_W-1:0]      kw_reg, kw_next;
    logic [4:0]           cat_reg, cat_next;
    logic                 scan_pend_reg, scan_pend_next;
    logic                 score_pend_reg, score_pend_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [KW_W-1:0]      pend_kw_reg, pend_kw_next;
    logic [CNT_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     best_score_reg, best_score_next;
    logic [3:0]           best_cat_reg, best_cat_next;
    logic                 res_valid_reg, res_valid_next;
    res_t                 res_reg, res_next;
    logic [4:0]           used;
    logic [SLOT_W-1:0]    cmd_slot;

    // Keyword row and match state memories.
    logic                 row_we;
    logic [SLOT_W-1:0]    row_raddr;
    logic [ROW_W-1:0]     row_wdata, row_rdata;
    logic                 st_we;
    logic [ST_W-1:0]      st_wdata, st_rdata;

    // Scan datapath.
    logic [KEYWORD_CHARS-1:0] eq_vec, old_vec, new_vec;
    logic                     old_hit, new_hit, end_hit;
    logic [LEN_W-1:0]         row_len;
    logic [CHARS_W-1:0]       row_chars;
    logic                     out_free;

    kcs_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (slot_reg),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    kcs_ram #(.WIDTH(ST_W), .DEPTH(SLOTS)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (pend_slot_reg),
        .wdata (st_wdata),
        .raddr (slot_reg),
        .rdata (st_rdata)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    // Number of categories scored, saturated at the table size.
    assign used = (int'(cfg_reg) > USED_LIMIT) ? 5'(USED_LIMIT) : cfg_reg;

    // Slot of the keyword named by the head command.
    assign cmd_slot = SLOT_W'(int'(cmd.category) * KEYWORDS_PER_CATEGORY + int'(cmd.keyword));

    assign row_raddr = (state_reg == S_IDLE) ? cmd_slot : slot_reg;
    assign row_len   = row_rdata[ROW_W-1 -: LEN_W];
    assign row_chars = row_rdata[CHARS_W-1:0];

    // Row update for a keyword character load.
    always_comb
    begin
        row_wdata = row_rdata;
        row_wdata[POS_W'(cmd.position) * 8 +: 8] = cmd.char_value;
        if (cmd.end_flag)
        begin
            row_wdata[ROW_W-1 -: LEN_W] = LEN_W'(cmd.position) + LEN_W'(1);
        end
    end

    // Shift-and step of one keyword against the current text character.
    always_comb
    begin
        for (int p = 0; p < KEYWORD_CHARS; p++)
        begin
            eq_vec[p] = row_chars[p*8 +: 8] == cmd.char_value;
        end
        old_vec = valid_reg[pend_slot_reg] ? st_rdata[KEYWORD_CHARS-1:0] : '0;
        old_hit = valid_reg[pend_slot_reg] && st_rdata[ST_W-1];
        new_vec = {old_vec[KEYWORD_CHARS-2 >= 0 ? KEYWORD_CHARS-2 : 0:0], 1'b1} & eq_vec;
        if (KEYWORD_CHARS == 1)
        begin
            new_vec = eq_vec;
        end
        end_hit = 1'b0;
        if (row_len != '0 && int'(row_len) <= KEYWORD_CHARS)
        begin
            end_hit = new_vec[POS_W'(row_len - LEN_W'(1))];
        end
        new_hit  = old_hit || end_hit;
        st_wdata = {new_hit, new_vec};
        st_we    = scan_pend_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        kw_next         = kw_reg;
        cat_next        = cat_reg;
        scan_pend_next  = 1'b0;
        score_pend_next = 1'b0;
        pend_slot_next  = pend_slot_reg;
        pend_kw_next    = pend_kw_reg;
        sum_next        = sum_reg;
        best_score_next = best_score_reg;
        best_cat_next   = best_cat_reg;
        valid_next      = valid_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        row_we          = 1'b0;
        cnt_we          = 1'b0;
        cmd_pop         = 1'b0;

        // Finish the scan pipeline: mark the written slot as live.
        if (scan_pend_reg)
        begin
            valid_next[pend_slot_reg] = 1'b1;
        end

        // Finish the scoring pipeline: count a hit of a counted keyword.
        if (score_pend_reg && valid_reg[pend_slot_reg] && st_rdata[ST_W-1]
            && int'(pend_kw_reg) < int'(counts_reg[CAT_W'(cat_reg)]))
        begin
            sum_next = sum_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_CHAR:
                        begin
                            slot_next  = cmd_slot;
                            state_next = S_ROW_WR;
                        end
                        CMD_COUNT:
                        begin
                            cnt_we  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_TEXT:
                        begin
                            slot_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_ROW_WR:
            begin
                row_we     = 1'b1;
                cmd_pop    = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                scan_pend_next = 1'b1;
                pend_slot_next = slot_reg;
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            S_SCAN_END:
            begin
                if (cmd.end_flag)
                begin
                    slot_next       = '0;
                    kw_next         = '0;
                    cat_next        = '0;
                    sum_next        = '0;
                    best_score_next = '0;
                    best_cat_next   = '0;
                    state_next      = (used == 5'd0) ? S_EMIT : S_SCORE;
                end
                else
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCORE:
            begin
                score_pend_next = 1'b1;
                pend_slot_next  = slot_reg;
                pend_kw_next    = kw_reg;
                if (slot_reg != LAST_SLOT)
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                if (kw_reg == LAST_KW)
                begin
                    kw_next    = '0;
                    state_next = S_SUM_END;
                end
                else
                begin
                    kw_next = kw_reg + KW_W'(1);
                end
            end
            S_SUM_END:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (used == 5'd0)
                    begin
                        res_next = '0;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        if (sum_reg > best_score_reg)
                        begin
                            best_score_next = sum_reg;
                            best_cat_next   = cat_reg[3:0];
                        end
                        res_next.result_category = cat_reg[3:0];
                        res_next.score           = 5'(sum_reg);
                        res_next.last            = (cat_reg + 5'd1) == used;
                        res_next.best_category   = (sum_reg > best_score_reg) ?
                                                   cat_reg[3:0] : best_cat_reg;
                        res_next.found           = (sum_reg > best_score_reg) ||
                                                   (best_score_reg != '0);
                    end
                    if (used == 5'd0 || (cat_reg + 5'd1) == used)
                    begin
                        valid_next = '0;
                        cmd_pop    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cat_next   = cat_reg + 5'd1;
                        sum_next   = '0;
                        state_next = S_SCORE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_reg        <= '0;
            valid_reg      <= '0;
            scan_pend_reg  <= 1'b0;
            score_pend_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            for (int c = 0; c < CATEGORIES; c++)
            begin
                counts_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            scan_pend_reg  <= scan_pend_next;
            score_pend_reg <= score_pend_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (cnt_we)
            begin
                counts_reg[CAT_W'(cmd.category)] <= CNT_W'(cmd.keyword_count);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        kw_reg         <= kw_next;
        cat_reg        <= cat_next;
        pend_slot_reg  <= pend_slot_next;
        pend_kw_reg    <= pend_kw_next;
        sum_reg        <= sum_next;
        best_score_reg <= best_score_next;
        best_cat_reg   <= best_cat_next;
        res_reg        <= res_next;
    end

    // A scan result lands only right after a scan read was issued.
    a_scan_pend: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pend_reg |-> (state_reg == S_SCAN || state_reg == S_SCAN_END))
        else $error("scan data outside scan");
    // A score read lands only while the category sum is still open.
    a_score_pend: assert property (@(posedge clk) disable iff (!rst_n)
        score_pend_reg |-> (state_reg == S_SCORE || state_reg == S_SUM_END))
        else $error("score data outside scoring");
    // The last result of a run leaves all match state cleared.
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && state_next == S_IDLE) |=> valid_reg == '0)
        else $error("match state not cleared at end of run");

endmodule

### hw/rtl/keyword_category_scorer.sv
// Top level of the keyword category scorer.
//
//  channel   direction  handshake                 payload
//  req       in         req_valid / req_stall     req_t (op .. end_flag)
//  res       out        res_valid / res_stall     res_t (result_category .. found)
//  cfg       in         cfg_wr_en                 cfg_wr_data (categories_in_use)
//
// A keyword character load reads its row, then writes it back; a count load
// writes the count. A text character sweeps all CATEGORIES*KEYWORDS_PER_CATEGORY
// slots, one keyword per cycle through the match state memory port. The last
// text character then adds a score sweep over the keywords of each scored
// category, plus any output stall. Reset is asynchronous and clears all match
// state at once. The two-entry queue keeps taking requests, until it is full,
// while the back end is busy or the output register is stalled.
module keyword_category_scorer import kcs_pkg::*; #(
    parameter int CATEGORIES            = 16,
    parameter int KEYWORDS_PER_CATEGORY = 16,
    parameter int KEYWORD_CHARS         = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  req_t       req,
    output logic       req_stall,
    output logic       res_valid,
    output res_t       res,
    input  logic       res_stall,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    logic q_full;
    logic push;
    cmd_t push_data;
    logic pop;
    logic head_valid;
    cmd_t head;

    kcs_front #(
        .CATEGORIES            (CATEGORIES),
        .KEYWORDS_PER_CATEGORY (KEYWORDS_PER_CATEGORY),
        .KEYWORD_CHARS         (KEYWORD_CHARS)
    ) u_front (
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    kcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    kcs_back #(
        .CATEGORIES            (CATEGORIES),
        .KEYWORDS_PER_CATEGORY (KEYWORDS_PER_CATEGORY),
        .KEYWORD_CHARS         (KEYWORD_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (head_valid),
        .cmd         (head),
        .cmd_pop     (pop),
        .res_valid   (res_valid),
        .res         (res),
        .res_stall   (res_stall)
    );

endmodule
